@@ sv/fqsm_pkg.sv @@
package fqsm_pkg;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_LIST   = 3'd2;
  localparam logic [2:0] CMD_SEARCH = 3'd3;
  localparam logic [2:0] CMD_MEAN   = 3'd4;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned DVD_W     = SUM_W + FRAC_BITS;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_LIST,
    OP_SEARCH,
    OP_MEAN,
    OP_UNKNOWN
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT,
    S_RM_RD,
    S_RM_EMIT,
    S_WK_RD,
    S_WK_CHK,
    S_SR_END,
    S_MEAN
  } state_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] operand;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] item_value;
    logic [4:0]         position;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         occupancy;
    logic signed [39:0] mean_fixed;
    logic               last;
  } res_t;

endpackage

@@ sv/fqsm_if.sv @@
interface fqsm_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] operand;

  modport source (output valid, command, operand, input ready);
  modport sink (input valid, command, operand, output ready);
endinterface

interface fqsm_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] item_value;
  logic [4:0]         position;
  logic signed [31:0] front_value;
  logic signed [31:0] back_value;
  logic [4:0]         occupancy;
  logic signed [39:0] mean_fixed;
  logic               last;

  modport source (output valid, status, item_value, position, front_value, back_value,
                  occupancy, mean_fixed, last, input ready);
  modport sink (input valid, status, item_value, position, front_value, back_value,
                occupancy, mean_fixed, last, output ready);
endinterface

@@ sv/fqsm_ram.sv @@
module fqsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/fqsm_div.sv @@
module fqsm_div #(
  parameter int CW = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [39:0]     sum,
  input  logic [CW-1:0]          divisor,
  output logic                   done,
  output logic signed [39:0]     quot
);

  localparam int DW = fqsm_pkg::DVD_W;
  localparam int FB = fqsm_pkg::FRAC_BITS;

  logic          busy;
  logic          neg;
  logic [DW-1:0] dvd;
  logic [CW-1:0] rem;
  logic [CW-1:0] dsr;
  logic [5:0]    cnt;
  logic [39:0]   mag;
  logic [CW:0]   trial;
  logic          take;

  assign mag   = sum[39] ? 40'(-sum) : 40'(sum);
  assign trial = {rem, dvd[DW-1]};
  assign take  = trial >= {1'b0, dsr};
  assign quot  = neg ? -$signed(dvd[39:0]) : $signed(dvd[39:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == 6'(DW - 1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {mag, {FB{1'b0}}};
      rem <= '0;
      cnt <= '0;
      neg <= sum[39];
      dsr <= divisor;
    end else if (busy) begin
      rem <= take ? CW'(trial - {1'b0, dsr}) : trial[CW-1:0];
      dvd <= {dvd[DW-2:0], take};
      cnt <= cnt + 6'd1;
    end
  end

endmodule

@@ sv/fqsm_front.sv @@
module fqsm_front (
  input  logic              clk,
  input  logic              rst,
  fqsm_cmd_if.sink          req,
  output logic              q_valid,
  input  logic              q_ready,
  output fqsm_pkg::req_t    q_data
);

  fqsm_pkg::req_t slot [2];
  fqsm_pkg::req_t dec;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     cnt;
  logic           push;
  logic           pop;

  always_comb begin
    dec.operand = req.operand;
    unique case (req.command)
      fqsm_pkg::CMD_INSERT: dec.op = fqsm_pkg::OP_INSERT;
      fqsm_pkg::CMD_REMOVE: dec.op = fqsm_pkg::OP_REMOVE;
      fqsm_pkg::CMD_LIST:   dec.op = fqsm_pkg::OP_LIST;
      fqsm_pkg::CMD_SEARCH: dec.op = fqsm_pkg::OP_SEARCH;
      fqsm_pkg::CMD_MEAN:   dec.op = fqsm_pkg::OP_MEAN;
      default:              dec.op = fqsm_pkg::OP_UNKNOWN;
    endcase
  end

  assign req.ready = cnt != 2'd2;
  assign push      = req.valid && req.ready;
  assign q_valid   = cnt != 2'd0;
  assign pop       = q_valid && q_ready;
  assign q_data    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= dec;
    end
  end

endmodule

@@ sv/fqsm_exec.sv @@
module fqsm_exec #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  fqsm_pkg::req_t    q_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fqsm_pkg::res_t    out_res
);

  localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fqsm_pkg::state_t   state;
  fqsm_pkg::state_t   state_next;
  fqsm_pkg::op_t      op;
  logic signed [31:0] operand;
  fqsm_pkg::status_t  sav_status;
  logic signed [31:0] sav_item;
  logic [AW-1:0]      head;
  logic [AW-1:0]      tail;
  logic [AW-1:0]      ptr;
  logic [CW-1:0]      count;
  logic [CW-1:0]      k;
  logic signed [39:0] sum;
  logic signed [31:0] front;
  logic signed [31:0] back;
  logic               pend_valid;
  logic [4:0]         pend_pos;

  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [31:0]        rd_data;
  logic               div_start;
  logic               div_done;
  logic signed [39:0] div_q;

  logic               emit;
  fqsm_pkg::res_t     eres;
  logic               out_free;
  logic               match;
  logic               k_last;
  logic               full;
  logic               empty;
  logic               walk_step;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  fqsm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (operand),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  fqsm_div #(.CW(CW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .sum     (sum),
    .divisor (count),
    .done    (div_done),
    .quot    (div_q)
  );

  assign out_free = !out_valid || out_ready;
  assign match    = $signed(rd_data) == operand;
  assign k_last   = (k + CW'(1)) == count;
  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;
  assign q_ready  = state == fqsm_pkg::S_IDLE;
  assign walk_step = state == fqsm_pkg::S_WK_CHK && state_next != fqsm_pkg::S_WK_CHK;

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    emit       = 1'b0;
    ram_raddr  = (state == fqsm_pkg::S_WK_RD || state == fqsm_pkg::S_WK_CHK) ? ptr : head;
    eres.status      = sav_status;
    eres.item_value  = sav_item;
    eres.position    = '0;
    eres.front_value = empty ? '0 : front;
    eres.back_value  = empty ? '0 : back;
    eres.occupancy   = 5'(count);
    eres.mean_fixed  = '0;
    eres.last        = 1'b1;
    unique case (state)
      fqsm_pkg::S_IDLE: begin
        if (q_valid) begin
          state_next = fqsm_pkg::S_EXEC;
        end
      end
      fqsm_pkg::S_EXEC: begin
        state_next = fqsm_pkg::S_EMIT;
        unique case (op)
          fqsm_pkg::OP_INSERT: ram_we = !full;
          fqsm_pkg::OP_REMOVE: begin
            if (!empty) begin
              state_next = fqsm_pkg::S_RM_RD;
            end
          end
          fqsm_pkg::OP_LIST, fqsm_pkg::OP_SEARCH: begin
            if (!empty) begin
              state_next = fqsm_pkg::S_WK_RD;
            end
          end
          fqsm_pkg::OP_MEAN: begin
            if (!empty) begin
              div_start  = 1'b1;
              state_next = fqsm_pkg::S_MEAN;
            end
          end
          default: ;
        endcase
      end
      fqsm_pkg::S_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = fqsm_pkg::S_IDLE;
        end
      end
      fqsm_pkg::S_RM_RD: state_next = fqsm_pkg::S_RM_EMIT;
      fqsm_pkg::S_RM_EMIT: begin
        eres.front_value = empty ? '0 : $signed(rd_data);
        if (out_free) begin
          emit       = 1'b1;
          state_next = fqsm_pkg::S_IDLE;
        end
      end
      fqsm_pkg::S_WK_RD: state_next = fqsm_pkg::S_WK_CHK;
      fqsm_pkg::S_WK_CHK: begin
        eres.status = fqsm_pkg::ST_OK;
        if (op == fqsm_pkg::OP_LIST) begin
          eres.item_value = $signed(rd_data);
          eres.position   = 5'(k + CW'(1));
          eres.last       = k_last;
          if (out_free) begin
            emit       = 1'b1;
            state_next = k_last ? fqsm_pkg::S_IDLE : fqsm_pkg::S_WK_RD;
          end
        end else begin
          eres.item_value = operand;
          eres.position   = pend_pos;
          eres.last       = 1'b0;
          if (!(match && pend_valid) || out_free) begin
            emit       = match && pend_valid;
            state_next = k_last ? fqsm_pkg::S_SR_END : fqsm_pkg::S_WK_RD;
          end
        end
      end
      fqsm_pkg::S_SR_END: begin
        if (pend_valid) begin
          eres.status     = fqsm_pkg::ST_OK;
          eres.item_value = operand;
          eres.position   = pend_pos;
        end else begin
          eres.status     = fqsm_pkg::ST_NOT_FOUND;
          eres.item_value = '0;
        end
        if (out_free) begin
          emit       = 1'b1;
          state_next = fqsm_pkg::S_IDLE;
        end
      end
      fqsm_pkg::S_MEAN: begin
        eres.status     = fqsm_pkg::ST_OK;
        eres.item_value = '0;
        eres.mean_fixed = div_q;
        if (div_done && out_free) begin
          emit       = 1'b1;
          state_next = fqsm_pkg::S_IDLE;
        end
      end
      default: state_next = fqsm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fqsm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      sum        <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (state == fqsm_pkg::S_EXEC) begin
        pend_valid <= 1'b0;
        if (op == fqsm_pkg::OP_INSERT && !full) begin
          tail  <= wrap_inc(tail);
          count <= count + CW'(1);
          sum   <= sum + 40'(operand);
        end
        if (op == fqsm_pkg::OP_REMOVE && !empty) begin
          head  <= wrap_inc(head);
          count <= count - CW'(1);
          sum   <= sum - 40'(front);
        end
      end
      if (walk_step && op == fqsm_pkg::OP_SEARCH && match) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == fqsm_pkg::S_IDLE && q_valid) begin
      op      <= q_data.op;
      operand <= q_data.operand;
    end
    if (state == fqsm_pkg::S_EXEC) begin
      ptr <= head;
      k   <= '0;
      unique case (op)
        fqsm_pkg::OP_INSERT: begin
          sav_status <= full ? fqsm_pkg::ST_FULL : fqsm_pkg::ST_OK;
          sav_item   <= operand;
          if (!full) begin
            back <= operand;
            if (empty) begin
              front <= operand;
            end
          end
        end
        fqsm_pkg::OP_REMOVE: begin
          sav_status <= empty ? fqsm_pkg::ST_EMPTY : fqsm_pkg::ST_OK;
          sav_item   <= empty ? '0 : front;
        end
        fqsm_pkg::OP_UNKNOWN: begin
          sav_status <= fqsm_pkg::ST_OK;
          sav_item   <= '0;
        end
        default: begin
          sav_status <= fqsm_pkg::ST_EMPTY;
          sav_item   <= '0;
        end
      endcase
    end
    if (state == fqsm_pkg::S_RM_EMIT) begin
      front <= $signed(rd_data);
    end
    if (walk_step) begin
      ptr <= wrap_inc(ptr);
      k   <= k + CW'(1);
      if (match) begin
        pend_pos <= 5'(k + CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res <= eres;
    end
  end

endmodule

@@ sv/fifo_queue_search_mean.sv @@
// Bounded FIFO of signed 32-bit words with list, search and mean commands.
// Requests arrive on req (command, operand) and results leave on rsp; both
// channels move a request when valid and ready are high at a rising edge.
// A two-entry command queue sits in front of the execution engine, so a
// new request is taken while the engine works or waits on the receiver.
// Each command yields one result, except list (one per entry) and search
// (one per match, else one not-found result); last marks a command's final result.
// Insert and unknown commands pass from the execute state to the emit state;
// remove reads the new front from the entry store before its result. List
// reads each entry from the store and checks it in a state of its own, giving
// one result per entry; search walks the same way and adds a closing state.
// Mean runs a restoring divider that makes one quotient bit a cycle over 48
// bits. The engine runs one command at a time.
// Synchronous reset empties both queues and clears their pointers and the sum.
// When rsp is stalled the result register holds its value and the engine
// waits in place; requests keep queuing until the command queue is full.
module fifo_queue_search_mean #(
  parameter int DEPTH = 16
) (
  input logic         clk,
  input logic         rst,
  fqsm_cmd_if.sink    req,
  fqsm_res_if.source  rsp
);

  logic           q_valid;
  logic           q_ready;
  fqsm_pkg::req_t q_data;
  fqsm_pkg::res_t res;

  fqsm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data)
  );

  fqsm_exec #(.DEPTH(DEPTH)) u_exec (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_res   (res)
  );

  assign rsp.status      = res.status;
  assign rsp.item_value  = res.item_value;
  assign rsp.position    = res.position;
  assign rsp.front_value = res.front_value;
  assign rsp.back_value  = res.back_value;
  assign rsp.occupancy   = res.occupancy;
  assign rsp.mean_fixed  = res.mean_fixed;
  assign rsp.last        = res.last;

endmodule

@@ tb/tb_top.sv @@
module tb_top;

  localparam int DEPTH = 16;
  localparam int unsigned LIMIT_CYCLES = 400000;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] item_value;
    logic [4:0]         position;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         occupancy;
    logic signed [39:0] mean_fixed;
    logic               last;
  } result_t;

  class fifo_scoreboard;
    logic signed [31:0] ring[DEPTH];
    int                 head;
    int                 count;
    logic signed [39:0] sum;
    result_t            pending[$];
    int                 errors;
    int                 checked;

    function new();
      head = 0;
      count = 0;
      sum = '0;
      errors = 0;
      checked = 0;
    endfunction

    function logic signed [31:0] at(int k);
      return ring[(head + k) % DEPTH];
    endfunction

    function void push_result(logic [1:0] st, logic signed [31:0] item, int pos,
                              logic signed [39:0] mean, bit fin);
      result_t r;
      r.status = st;
      r.item_value = item;
      r.position = pos[4:0];
      r.front_value = count != 0 ? at(0) : 32'sd0;
      r.back_value = count != 0 ? at(count - 1) : 32'sd0;
      r.occupancy = count[4:0];
      r.mean_fixed = mean;
      r.last = fin;
      pending.push_back(r);
    endfunction

    function void note_request(logic [2:0] cmd, logic signed [31:0] opnd);
      int                 hits;
      logic signed [31:0] v;
      logic signed [47:0] scaled;
      hits = 0;
      if (cmd <= fqsm_pkg::CMD_MEAN && cmd != fqsm_pkg::CMD_INSERT && count == 0) begin
        push_result(fqsm_pkg::ST_EMPTY, 0, 0, 0, 1);
        return;
      end
      case (cmd)
        fqsm_pkg::CMD_INSERT: begin
          if (count >= DEPTH) begin
            push_result(fqsm_pkg::ST_FULL, opnd, 0, 0, 1);
          end else begin
            ring[(head + count) % DEPTH] = opnd;
            count++;
            sum += opnd;
            push_result(fqsm_pkg::ST_OK, opnd, 0, 0, 1);
          end
        end
        fqsm_pkg::CMD_REMOVE: begin
          v = at(0);
          head = (head + 1) % DEPTH;
          count--;
          sum -= v;
          push_result(fqsm_pkg::ST_OK, v, 0, 0, 1);
        end
        fqsm_pkg::CMD_LIST: begin
          for (int k = 0; k < count; k++)
            push_result(fqsm_pkg::ST_OK, at(k), k + 1, 0, k + 1 == count);
        end
        fqsm_pkg::CMD_SEARCH: begin
          for (int k = 0; k < count; k++) begin
            if (at(k) == opnd) begin
              push_result(fqsm_pkg::ST_OK, opnd, k + 1, 0, 0);
              hits++;
            end
          end
          if (hits == 0) push_result(fqsm_pkg::ST_NOT_FOUND, 0, 0, 0, 1);
          else pending[$].last = 1;
        end
        fqsm_pkg::CMD_MEAN: begin
          scaled = $signed(sum) * 48'sd256;
          scaled = scaled / count;
          push_result(fqsm_pkg::ST_OK, 0, 0, scaled[39:0], 1);
        end
        default: push_result(fqsm_pkg::ST_OK, 0, 0, 0, 1);
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d item=%0d", $time, got.status,
                 got.item_value);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.item_value !== want.item_value) begin
        $display("%0t: item_value expected %0d actual %0d", $time, want.item_value,
                 got.item_value);
        errors++;
      end
      if (got.position !== want.position) begin
        $display("%0t: position expected %0d actual %0d", $time, want.position, got.position);
        errors++;
      end
      if (got.front_value !== want.front_value) begin
        $display("%0t: front_value expected %0d actual %0d", $time, want.front_value,
                 got.front_value);
        errors++;
      end
      if (got.back_value !== want.back_value) begin
        $display("%0t: back_value expected %0d actual %0d", $time, want.back_value,
                 got.back_value);
        errors++;
      end
      if (got.occupancy !== want.occupancy) begin
        $display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
                 got.occupancy);
        errors++;
      end
      if (got.mean_fixed !== want.mean_fixed) begin
        $display("%0t: mean_fixed expected %0d actual %0d", $time, want.mean_fixed,
                 got.mean_fixed);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   requests_sent;
  int unsigned cycle_count;
  fifo_scoreboard fifo_board;
  logic signed [31:0] recent_values[$];

  fqsm_cmd_if cmd_ch();
  fqsm_res_if res_ch();

  fifo_queue_search_mean #(.DEPTH(DEPTH)) u_dut (
    .clk(clk),
    .rst(rst),
    .req(cmd_ch.sink),
    .rsp(res_ch.source)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("Timeout after %0d cycles.", cycle_count);
        $display("fifo_queue_search_mean verification failed");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.status = res_ch.status;
        got.item_value = res_ch.item_value;
        got.position = res_ch.position;
        got.front_value = res_ch.front_value;
        got.back_value = res_ch.back_value;
        got.occupancy = res_ch.occupancy;
        got.mean_fixed = res_ch.mean_fixed;
        got.last = res_ch.last;
        fifo_board.check_result(got);
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(logic [2:0] cmd, logic signed [31:0] opnd);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= cmd;
    cmd_ch.operand <= opnd;
    do @(posedge clk); while (!cmd_ch.ready);
    fifo_board.note_request(cmd, opnd);
    requests_sent++;
    if (cmd == fqsm_pkg::CMD_INSERT) begin
      recent_values.push_back(opnd);
      if (recent_values.size() > 8) void'(recent_values.pop_front());
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh7fffffff - $urandom_range(2);
      2: return 32'sh80000000 + $urandom_range(2);
      3: return $urandom_range(6) - 3;
      default: return $urandom_range(40) - 20;
    endcase
  endfunction

  function automatic logic [2:0] pick_command();
    int r;
    r = $urandom_range(99);
    if (r < 40) return fqsm_pkg::CMD_INSERT;
    if (r < 65) return fqsm_pkg::CMD_REMOVE;
    if (r < 75) return fqsm_pkg::CMD_LIST;
    if (r < 88) return fqsm_pkg::CMD_SEARCH;
    if (r < 96) return fqsm_pkg::CMD_MEAN;
    return 3'($urandom_range(7, 5));
  endfunction

  task automatic random_phase(int n);
    logic [2:0]         cmd;
    logic signed [31:0] opnd;
    for (int i = 0; i < n; i++) begin
      cmd = pick_command();
      opnd = pick_value();
      if (cmd == fqsm_pkg::CMD_SEARCH && recent_values.size() != 0 &&
          $urandom_range(2) != 0)
        opnd = recent_values[$urandom_range(recent_values.size() - 1)];
      send_request(cmd, opnd);
    end
  endtask

  initial begin
    int wait_cycles;
    fifo_board = new();
    requests_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = fqsm_pkg::CMD_INSERT;
    cmd_ch.operand = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(fqsm_pkg::CMD_REMOVE, 0);
    send_request(fqsm_pkg::CMD_LIST, 0);
    send_request(fqsm_pkg::CMD_SEARCH, 5);
    send_request(fqsm_pkg::CMD_MEAN, 0);
    send_request(3'd5, 32'sh7fffffff);
    send_request(3'd7, 32'sh80000000);
    send_request(fqsm_pkg::CMD_INSERT, 32'sh7fffffff);
    send_request(fqsm_pkg::CMD_INSERT, 32'sh80000000);
    send_request(fqsm_pkg::CMD_MEAN, 0);
    send_request(fqsm_pkg::CMD_INSERT, 32'sh7fffffff);
    send_request(fqsm_pkg::CMD_SEARCH, 32'sh7fffffff);
    send_request(fqsm_pkg::CMD_SEARCH, 1);
    for (int i = 0; i < DEPTH - 3; i++) send_request(fqsm_pkg::CMD_INSERT, -32'sd7);
    send_request(fqsm_pkg::CMD_INSERT, 32'sd3);
    send_request(fqsm_pkg::CMD_LIST, 0);
    send_request(fqsm_pkg::CMD_MEAN, 0);
    send_request(fqsm_pkg::CMD_SEARCH, -32'sd7);
    send_request(fqsm_pkg::CMD_REMOVE, 0);

    send_idle_pct = 27;
    recv_idle_pct = 88;
    random_phase(150);
    send_idle_pct = 88;
    recv_idle_pct = 27;
    random_phase(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(150);
    cmd_ch.valid <= 1'b0;

    while (fifo_board.pending.size() != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < 100) begin
      @(posedge clk);
      wait_cycles++;
    end

    $display("Sent %0d requests covering all commands, full and empty queues, and stalls.",
             requests_sent);
    $display("Checked %0d results.", fifo_board.checked);
    if (fifo_board.errors == 0 && fifo_board.pending.size() == 0) begin
      $display("fifo_queue_search_mean verification clean");
    end else begin
      $display("fifo_queue_search_mean verification failed");
    end
    $finish;
  end
endmodule
